// ===== rtl/rsb_codec_pkg.sv =====
// Shared types and constants for the sensor-bus packet codec.
// Depends on nothing; imported by every module of the block.
package rsb_codec_pkg;

    // Item kinds on the request channel.
    typedef enum logic [1:0] {
        FUNC_RX_BYTE = 2'd0,
        FUNC_GAP     = 2'd1,
        FUNC_SEND    = 2'd2,
        FUNC_UNUSED  = 2'd3
    } func_t;

    // Result kinds.
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_TX     = 1'b1;

    localparam int RX_KEEP     = 4;             // bytes of a packet that are kept
    localparam int FRAME_MAX   = 8;             // longest transmit frame
    localparam int DATA_MAX    = 4;             // most data bytes in a frame
    localparam int FRAME_OVHD  = 4;             // length, header and two checksum bytes
    localparam logic [15:0] CSUM_BASE = 16'hFFFF;

    typedef struct packed {
        func_t      func;
        logic [7:0] rx_byte;
        logic [3:0] send_cmd;
        logic [3:0] send_sensor;
        logic [2:0] send_count;
        logic [7:0] send_data0;
        logic [7:0] send_data1;
        logic [7:0] send_data2;
        logic [7:0] send_data3;
    } in_t;

    typedef struct packed {
        logic       out_kind;
        logic [3:0] pkt_cmd;
        logic [3:0] pkt_sensor_id;
        logic       pkt_ok;
        logic [7:0] tx_byte;
        logic       tx_last;
    } out_t;

    // One unit of work for the emitter: either a single report or a frame.
    typedef struct packed {
        logic                      is_report;
        logic [3:0]                cmd;
        logic [3:0]                sensor_id;
        logic                      ok;
        logic [FRAME_MAX-1:0][7:0] frame;
        logic [2:0]                last_idx;
    } job_t;

endpackage

// ===== rtl/rsb_codec_decode.sv =====
// Receive state and request decode for the sensor-bus packet codec.
// Depends on rsb_codec_pkg; feeds jobs to rsb_codec_emit.
module rsb_codec_decode #(
    parameter int MAX_PACKET = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  rsb_codec_pkg::in_t   req,
    output logic                 job_valid,
    output rsb_codec_pkg::job_t  job
);
    import rsb_codec_pkg::*;

    localparam int IW = $clog2(MAX_PACKET + 1);

    logic [RX_KEEP-1:0][7:0] rx_buf_reg;
    logic [IW-1:0]           rx_index_reg, rx_index_next;
    logic                    gap_flag_reg, gap_flag_next;

    logic [IW-1:0]           idx_eff;
    logic                    store_en;
    logic [15:0]             expect_sum;
    logic [15:0]             got_sum;
    logic [2:0]              count;
    logic [DATA_MAX-1:0][7:0] data;
    logic [7:0]              len_byte;
    logic [7:0]              hdr_byte;
    logic [15:0]             sum;
    logic [15:0]             csum;

    always_comb begin
        // A byte after a gap starts a new packet.
        idx_eff       = gap_flag_reg ? '0 : rx_index_reg;
        store_en      = 1'b0;
        rx_index_next = rx_index_reg;
        gap_flag_next = gap_flag_reg;
        job_valid     = 1'b0;

        expect_sum = CSUM_BASE - {8'd0, rx_buf_reg[0]} - {8'd0, rx_buf_reg[1]};
        got_sum    = {req.rx_byte, rx_buf_reg[2]};

        count    = (req.send_count > 3'(DATA_MAX)) ? 3'(DATA_MAX) : req.send_count;
        data     = {req.send_data3, req.send_data2, req.send_data1, req.send_data0};
        len_byte = 8'(FRAME_OVHD) + {5'd0, count};
        hdr_byte = {req.send_cmd, req.send_sensor};
        sum      = {8'd0, len_byte} + {8'd0, hdr_byte};
        for (int i = 0; i < DATA_MAX; i++) begin
            if (3'(i) < count) begin
                sum = sum + {8'd0, data[2'(i)]};
            end
        end
        csum = CSUM_BASE - sum;

        job.is_report = 1'b0;
        job.cmd       = rx_buf_reg[1][7:4];
        job.sensor_id = rx_buf_reg[1][3:0];
        job.ok        = (expect_sum == got_sum);
        job.last_idx  = 3'(FRAME_OVHD - 1) + count;
        for (int i = 0; i < FRAME_MAX; i++) begin
            if (i == 0) begin
                job.frame[3'(i)] = len_byte;
            end else if (i == 1) begin
                job.frame[3'(i)] = hdr_byte;
            end else if (4'(i - 2) < {1'b0, count}) begin
                job.frame[3'(i)] = data[2'(i - 2)];
            end else if (4'(i - 2) == {1'b0, count}) begin
                job.frame[3'(i)] = csum[7:0];
            end else if (4'(i - 3) == {1'b0, count}) begin
                job.frame[3'(i)] = csum[15:8];
            end else begin
                job.frame[3'(i)] = 8'd0;
            end
        end

        if (accept) begin
            unique case (req.func)
                FUNC_RX_BYTE: begin
                    gap_flag_next = 1'b0;
                    rx_index_next = idx_eff;
                    if (idx_eff < IW'(MAX_PACKET)) begin
                        rx_index_next = idx_eff + 1'b1;
                        store_en      = (idx_eff < IW'(RX_KEEP));
                        if (idx_eff == IW'(RX_KEEP - 1)) begin
                            job_valid     = 1'b1;
                            job.is_report = 1'b1;
                        end
                    end
                end
                FUNC_GAP: begin
                    gap_flag_next = 1'b1;
                end
                FUNC_SEND: begin
                    job_valid = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_index_reg <= '0;
            gap_flag_reg <= 1'b0;
        end else begin
            rx_index_reg <= rx_index_next;
            gap_flag_reg <= gap_flag_next;
        end
    end

    // Buffer contents only matter once written, so it carries no reset.
    always_ff @(posedge aclk) begin
        if (store_en) begin
            rx_buf_reg[idx_eff[1:0]] <= req.rx_byte;
        end
    end

endmodule

// ===== rtl/rsb_codec_emit.sv =====
// Job holding register and result register for the sensor-bus packet codec.
// Depends on rsb_codec_pkg; takes jobs from rsb_codec_decode.
module rsb_codec_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 job_load,
    input  rsb_codec_pkg::job_t  job_in,
    output logic                 job_free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rsb_codec_pkg::out_t  m_payload
);
    import rsb_codec_pkg::*;

    job_t       job_reg;
    logic       busy_reg, busy_next;
    logic [2:0] pos_reg, pos_next;
    logic       m_valid_reg, m_valid_next;
    out_t       m_payload_reg, m_payload_next;

    logic out_free;
    logic emit;
    logic at_last;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = busy_reg && out_free;
    assign at_last  = job_reg.is_report || (pos_reg == job_reg.last_idx);
    // A new request may be taken in the same cycle the final result leaves.
    assign job_free = !busy_reg || (out_free && at_last);

    always_comb begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;

        if (emit) begin
            m_valid_next = 1'b1;
            if (job_reg.is_report) begin
                m_payload_next = '{out_kind: KIND_REPORT, pkt_cmd: job_reg.cmd,
                                   pkt_sensor_id: job_reg.sensor_id, pkt_ok: job_reg.ok,
                                   tx_byte: 8'd0, tx_last: 1'b0};
            end else begin
                m_payload_next = '{out_kind: KIND_TX, pkt_cmd: 4'd0, pkt_sensor_id: 4'd0,
                                   pkt_ok: 1'b0, tx_byte: job_reg.frame[pos_reg],
                                   tx_last: at_last};
            end
            pos_next = pos_reg + 1'b1;
            if (at_last) begin
                busy_next = 1'b0;
            end
        end

        if (job_load) begin
            busy_next = 1'b1;
            pos_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
        if (job_load) begin
            job_reg <= job_in;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// ===== rtl/rc_sensor_bus_packet_codec.sv =====
// Top level of the sensor-bus packet codec.
// Depends on rsb_codec_pkg, rsb_codec_decode and rsb_codec_emit.
//
// Each request is a received bus byte, a line-gap mark or a send order. Bytes
// and gap marks that yield no result are absorbed; the fourth byte of a packet
// yields one report (command, sensor id, checksum status) through the job
// register and then the result register. A send order yields the framed packet,
// 4 to 8 bytes, one per cycle from the result register while it is not stalled;
// the job register is freed as its final byte moves out, letting the next
// request be accepted in that same cycle. MAX_PACKET sets how many bytes of one
// packet are counted before further bytes are dropped until the next gap.
module rc_sensor_bus_packet_codec #(
    parameter int MAX_PACKET = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rsb_codec_pkg::in_t   s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rsb_codec_pkg::out_t  m_payload
);
    import rsb_codec_pkg::*;

    logic accept;
    logic job_valid;
    logic job_free;
    job_t job;

    assign s_ready = job_free;
    assign accept  = s_valid && s_ready;

    rsb_codec_decode #(
        .MAX_PACKET (MAX_PACKET)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .req       (s_payload),
        .job_valid (job_valid),
        .job       (job)
    );

    rsb_codec_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_load  (job_valid),
        .job_in    (job),
        .job_free  (job_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the sensor-bus packet codec: directed and random
// requests with random idling on both channels, each result checked on the fly.
// Depends on rsb_codec_pkg and rc_sensor_bus_packet_codec.
module tb;
    import rsb_codec_pkg::*;

    localparam int CAPACITY    = 8;
    localparam int ITEM_TARGET = 270;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 16;

    // Keeps its own copy of the receive state and the queue of results that
    // the accepted requests should produce.
    class packet_tracker;
        logic [7:0] held [RX_KEEP];
        int         fill;
        bit         gap_seen;
        out_t       due [$];
        int         errors;

        function new();
            fill     = 0;
            gap_seen = 1'b0;
            errors   = 0;
            foreach (held[i]) held[i] = 8'h00;
        endfunction

        function void absorb(in_t req);
            logic [15:0] want_sum;
            logic [15:0] got_sum;
            logic [15:0] sum;
            logic [7:0]  frame [FRAME_MAX];
            int          cnt;
            int          len;
            out_t        res;
            case (req.func)
                FUNC_RX_BYTE: begin
                    if (gap_seen) begin
                        gap_seen = 1'b0;
                        fill     = 0;
                    end
                    if (fill < CAPACITY) begin
                        if (fill < RX_KEEP) held[fill] = req.rx_byte;
                        fill++;
                        if (fill == RX_KEEP) begin
                            want_sum          = CSUM_BASE - held[0] - held[1];
                            got_sum           = {held[3], held[2]};
                            res               = '0;
                            res.out_kind      = KIND_REPORT;
                            res.pkt_cmd       = held[1][7:4];
                            res.pkt_sensor_id = held[1][3:0];
                            res.pkt_ok        = (want_sum == got_sum);
                            due.push_back(res);
                        end
                    end
                end
                FUNC_GAP: gap_seen = 1'b1;
                FUNC_SEND: begin
                    cnt = (req.send_count > DATA_MAX) ? DATA_MAX : int'(req.send_count);
                    len = FRAME_OVHD + cnt;
                    frame[0] = 8'(len);
                    frame[1] = {req.send_cmd, req.send_sensor};
                    frame[2] = req.send_data0;
                    frame[3] = req.send_data1;
                    frame[4] = req.send_data2;
                    frame[5] = req.send_data3;
                    sum = 16'h0000;
                    for (int i = 0; i < 2 + cnt; i++) sum = sum + frame[i];
                    sum = CSUM_BASE - sum;
                    frame[2 + cnt] = sum[7:0];
                    frame[3 + cnt] = sum[15:8];
                    for (int i = 0; i < len; i++) begin
                        res          = '0;
                        res.out_kind = KIND_TX;
                        res.tx_byte  = frame[i];
                        res.tx_last  = (i == len - 1);
                        due.push_back(res);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void match(out_t got);
            out_t want;
            if (due.size() == 0) begin
                $error("result with nothing expected: %0h", got);
                errors++;
                return;
            end
            want = due.pop_front();
            check_field("out_kind", 8'(want.out_kind), 8'(got.out_kind));
            check_field("pkt_cmd", 8'(want.pkt_cmd), 8'(got.pkt_cmd));
            check_field("pkt_sensor_id", 8'(want.pkt_sensor_id), 8'(got.pkt_sensor_id));
            check_field("pkt_ok", 8'(want.pkt_ok), 8'(got.pkt_ok));
            check_field("tx_byte", want.tx_byte, got.tx_byte);
            check_field("tx_last", 8'(want.tx_last), 8'(got.tx_last));
        endfunction
    endclass

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    in_t           s_payload;
    logic          m_valid;
    logic          m_ready;
    out_t          m_payload;
    bit            calm;
    int            offered;
    int            cycles;
    packet_tracker tracker;

    always #1 aclk = ~aclk;

    rc_sensor_bus_packet_codec #(
        .MAX_PACKET(CAPACITY)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) tracker.absorb(s_payload);
            if (m_valid && m_ready) tracker.match(m_payload);
        end
    end

    function automatic int idle_cycles();
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic in_t request_of(func_t f);
        logic [63:0] bits;
        in_t         r;
        bits   = {$urandom(), $urandom()};
        r      = bits[$bits(in_t)-1:0];
        r.func = f;
        return r;
    endfunction

    function automatic in_t rx_item(logic [7:0] b);
        in_t r;
        r         = request_of(FUNC_RX_BYTE);
        r.rx_byte = b;
        return r;
    endfunction

    function automatic in_t send_item(logic [3:0] c, logic [3:0] s, logic [2:0] n,
                                      logic [31:0] data);
        in_t r;
        r             = request_of(FUNC_SEND);
        r.send_cmd    = c;
        r.send_sensor = s;
        r.send_count  = n;
        {r.send_data0, r.send_data1, r.send_data2, r.send_data3} = data;
        return r;
    endfunction

    task automatic offer(in_t r);
        int n;
        n = idle_cycles();
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_payload <= r;
        do @(posedge aclk); while (!s_ready);
        if (r.func != FUNC_UNUSED) offered++;
    endtask

    // A four-byte packet, optionally after a gap; a bad one has its checksum
    // bytes spoilt so that the check cannot pass by chance.
    task automatic feed_packet(logic [7:0] b0, logic [7:0] b1, bit good, bit lead_gap);
        logic [15:0] csum;
        csum = CSUM_BASE - b0 - b1;
        if (!good) csum = csum ^ 16'($urandom_range(1, 65535));
        if (lead_gap) offer(request_of(FUNC_GAP));
        offer(rx_item(b0));
        offer(rx_item(b1));
        offer(rx_item(csum[7:0]));
        offer(rx_item(csum[15:8]));
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            n = idle_cycles();
            repeat (n) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && aresetn));
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb: errors");
        $finish;
    end

    initial begin
        int  pick;
        int  extra;
        bit  paused;
        in_t r;
        tracker   = new();
        s_valid   = 1'b0;
        s_payload = '0;
        aresetn   = 1'b0;
        calm      = 1'b0;
        offered   = 0;
        paused    = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: unused selector, a packet straight after reset, an
        // overfull packet, a bad checksum, the shortest and longest sends and oversized counts.
        r = request_of(FUNC_UNUSED);
        offer(r | '1);
        feed_packet(8'h04, 8'hFF, 1'b1, 1'b0);
        repeat (5) offer(rx_item(8'hAA));
        feed_packet(8'h00, 8'h00, 1'b0, 1'b1);
        offer(send_item(4'h0, 4'h0, 3'd0, 32'h0000_0000));
        offer(send_item(4'hF, 4'hF, 3'd4, 32'hFFFF_FFFF));
        offer(send_item(4'hA, 4'h5, 3'd7, 32'h1234_5678));
        offer(send_item(4'h3, 4'hC, 3'd5, 32'h8000_0001));
        feed_packet(8'hFF, 8'hFF, 1'b1, 1'b1);
        r = request_of(FUNC_UNUSED);
        offer(r & in_t'({FUNC_UNUSED, 51'd0}));

        // Random part: mostly well-formed packets and send requests.
        while (offered < ITEM_TARGET) begin
            if (!paused && offered >= ITEM_TARGET / 2) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) calm = !calm;
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                feed_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            $urandom_range(0, 4) != 0, $urandom_range(0, 9) != 0);
                extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
                repeat (extra) offer(rx_item(8'($urandom_range(0, 255))));
            end else if (pick < 80) begin
                r = request_of(FUNC_SEND);
                if ($urandom_range(0, 4) != 0) r.send_count = 3'($urandom_range(0, 4));
                offer(r);
            end else if (pick < 88) begin
                offer(rx_item(8'($urandom_range(0, 255))));
            end else if (pick < 95) begin
                offer(request_of(FUNC_GAP));
            end else begin
                offer(request_of(FUNC_UNUSED));
            end
        end

        drain();
        if (tracker.errors == 0 && tracker.due.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
